/* hw/rtl/mbtcp_pkg.sv */
package mbtcp_pkg;

  localparam int ADU_BUFFER_SIZE = 260;
  localparam logic [15:0] PAYLOAD_MAX = 16'(ADU_BUFFER_SIZE - 8);

  localparam logic [1:0] CMD_BEGIN   = 2'd0;
  localparam logic [1:0] CMD_PAYLOAD = 2'd1;
  localparam logic [1:0] CMD_RESP    = 2'd2;

  localparam logic [0:0] REG_SERVER_MODE = 1'd0;
  localparam logic [0:0] REG_MAX_OUT_LEN = 1'd1;

  localparam logic [3:0] ST_GOOD     = 4'd0;
  localparam logic [3:0] ST_PENDING  = 4'd1;
  localparam logic [3:0] ST_BUSY     = 4'd2;
  localparam logic [3:0] ST_OVERFLOW = 4'd3;
  localparam logic [3:0] ST_SHORT    = 4'd4;
  localparam logic [3:0] ST_PREFIX   = 4'd5;
  localparam logic [3:0] ST_TRANS    = 4'd6;
  localparam logic [3:0] ST_UNIT     = 4'd7;
  localparam logic [3:0] ST_EXCEPT   = 4'd8;
  localparam logic [3:0] ST_FUNC     = 4'd9;

  localparam logic [7:0] MAX_OUT_LEN_RST = 8'd252;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] unit_id;
    logic [7:0] func_code;
    logic [7:0] payload_len;
    logic       repeat_request;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       tx_last;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       frame_done;
    logic [3:0] status;
    logic [7:0] exception_code;
    logic [7:0] resp_unit;
    logic [7:0] resp_func;
  } out_word_t;

endpackage

/* hw/rtl/modbus_tcp_adu_framer_checker.sv */
// A result is registered into the output register in the cycle after its word is accepted.
// Payload and response words run at one per cycle while out_ready does not hold off the output;
// an accepted begin word yields eight header words, and input is held off while the last seven
// are sent. A rejected begin yields one word. Words that produce nothing yield no output word.
// Reset (synchronous, rst_n low) clears all state but out_r and hdr_r and restores the register defaults.
module modbus_tcp_adu_framer_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mbtcp_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mbtcp_pkg::out_word_t out_data,
  input  logic                 cfg_we,
  input  logic [0:0]           cfg_index,
  input  logic [7:0]           cfg_wdata
);
  import mbtcp_pkg::*;

  logic        server_mode_r;
  logic [7:0]  max_out_len_r;

  logic [15:0] tid_r, tid_nxt;
  logic [7:0]  req_unit_r, req_unit_nxt;
  logic [7:0]  req_func_r, req_func_nxt;
  logic        busy_r, busy_nxt;
  logic [7:0]  tx_left_r, tx_left_nxt;
  logic [16:0] rx_count_r, rx_count_nxt;
  logic [15:0] rx_len_r, rx_len_nxt;
  logic [15:0] rx_tid_r, rx_tid_nxt;
  logic [3:0]  rx_err_r, rx_err_nxt;
  logic [7:0]  rx_exc_r, rx_exc_nxt;
  logic [7:0]  rx_unit_r, rx_unit_nxt;
  logic [7:0]  rx_func_r, rx_func_nxt;

  // Header bytes still to send after the first one of a begin.
  logic [6:0][7:0] hdr_r, hdr_nxt;
  logic [2:0]      hdr_left_r;
  logic            hdr_last_r, hdr_last_nxt;
  logic            hdr_start;

  out_word_t out_r, res;
  out_word_t hdr_word;
  logic      out_valid_r;
  logic      res_vld;
  logic      in_fire;
  logic      out_free;

  logic [15:0] limit;
  logic [15:0] tid_new;
  logic [15:0] len;
  logic [16:0] cnt_inc;
  logic [16:0] pay_idx;
  logic        pass;
  logic        done;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (hdr_left_r == 3'd0) && out_free;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign limit = ({8'd0, max_out_len_r} > PAYLOAD_MAX) ? PAYLOAD_MAX : {8'd0, max_out_len_r};

  always_comb begin
    hdr_word          = '0;
    hdr_word.tx_byte  = hdr_r[6];
    hdr_word.tx_valid = 1'b1;
    hdr_word.tx_last  = (hdr_left_r == 3'd1) && hdr_last_r;
  end

  always_comb begin
    tid_nxt      = tid_r;
    req_unit_nxt = req_unit_r;
    req_func_nxt = req_func_r;
    busy_nxt     = busy_r;
    tx_left_nxt  = tx_left_r;
    rx_count_nxt = rx_count_r;
    rx_len_nxt   = rx_len_r;
    rx_tid_nxt   = rx_tid_r;
    rx_err_nxt   = rx_err_r;
    rx_exc_nxt   = rx_exc_r;
    rx_unit_nxt  = rx_unit_r;
    rx_func_nxt  = rx_func_r;
    hdr_nxt      = hdr_r;
    hdr_last_nxt = hdr_last_r;
    hdr_start    = 1'b0;
    res          = '0;
    res_vld      = 1'b0;
    tid_new      = tid_r;
    len          = {8'd0, in_data.payload_len} + 16'd2;
    cnt_inc      = rx_count_r + 17'd1;
    pay_idx      = rx_count_r - 17'd8;
    pass         = 1'b0;
    done         = 1'b0;
    if (in_fire) begin
      case (in_data.cmd)
        CMD_BEGIN: begin
          res_vld = 1'b1;
          if (!server_mode_r && busy_r) begin
            res.frame_done = 1'b1;
            res.status     = ST_BUSY;
          end else if ({8'd0, in_data.payload_len} > PAYLOAD_MAX) begin
            res.frame_done = 1'b1;
            res.status     = ST_OVERFLOW;
          end else begin
            if (!server_mode_r) begin
              if (!in_data.repeat_request) begin
                tid_new = tid_r + 16'd1;
              end
              req_unit_nxt = in_data.unit_id;
              req_func_nxt = in_data.func_code;
              busy_nxt     = 1'b1;
            end
            tid_nxt      = tid_new;
            tx_left_nxt  = in_data.payload_len;
            res.tx_byte  = tid_new[15:8];
            res.tx_valid = 1'b1;
            hdr_start    = 1'b1;
            hdr_nxt      = {tid_new[7:0], 8'h00, 8'h00, len[15:8], len[7:0],
                            in_data.unit_id, in_data.func_code};
            hdr_last_nxt = (in_data.payload_len == 8'd0);
          end
        end
        CMD_PAYLOAD: begin
          if (tx_left_r != 8'd0) begin
            tx_left_nxt  = tx_left_r - 8'd1;
            res_vld      = 1'b1;
            res.tx_byte  = in_data.data_byte;
            res.tx_valid = 1'b1;
            res.tx_last  = (tx_left_r == 8'd1);
          end
        end
        CMD_RESP: begin
          res_vld = 1'b1;
          case (rx_count_r)
            17'd0: begin
              rx_err_nxt  = ST_GOOD;
              rx_exc_nxt  = 8'd0;
              rx_unit_nxt = 8'd0;
              rx_func_nxt = 8'd0;
              rx_len_nxt  = 16'd0;
              rx_tid_nxt  = {in_data.data_byte, 8'd0};
            end
            17'd1: rx_tid_nxt = {rx_tid_r[15:8], in_data.data_byte};
            17'd2, 17'd3: begin
              if (in_data.data_byte != 8'd0 && rx_err_r == ST_GOOD) begin
                rx_err_nxt = ST_PREFIX;
              end
            end
            17'd4: rx_len_nxt = {in_data.data_byte, 8'd0};
            17'd5: begin
              rx_len_nxt = {rx_len_r[15:8], in_data.data_byte};
              if (rx_len_nxt < 16'd2) begin
                rx_err_nxt = ST_SHORT;
              end else if (rx_err_r == ST_GOOD) begin
                if (server_mode_r) begin
                  tid_nxt = rx_tid_r;
                end else if (rx_tid_r != tid_r) begin
                  rx_err_nxt = ST_TRANS;
                end
              end
            end
            17'd6: begin
              rx_unit_nxt = in_data.data_byte;
              if (rx_err_r == ST_GOOD && !server_mode_r &&
                  in_data.data_byte != req_unit_r) begin
                rx_err_nxt = ST_UNIT;
              end
            end
            17'd7: begin
              rx_func_nxt = in_data.data_byte;
              if (rx_err_r == ST_GOOD && !server_mode_r) begin
                if (in_data.data_byte[7]) begin
                  rx_err_nxt = (rx_len_r > 16'd2) ? ST_EXCEPT : ST_FUNC;
                end else if (in_data.data_byte != req_func_r) begin
                  rx_err_nxt = ST_FUNC;
                end
              end
            end
            default: begin
              if (rx_err_r == ST_EXCEPT && rx_count_r == 17'd8) begin
                rx_exc_nxt = in_data.data_byte;
              end else if (rx_err_r == ST_GOOD && pay_idx < {1'b0, limit}) begin
                pass = 1'b1;
              end
            end
          endcase
          done           = (cnt_inc >= 17'd6) && (cnt_inc == {1'b0, rx_len_nxt} + 17'd6);
          res.rx_byte    = pass ? in_data.data_byte : 8'd0;
          res.rx_valid   = pass;
          res.resp_unit  = rx_unit_nxt;
          res.resp_func  = rx_func_nxt;
          if (done) begin
            res.frame_done     = 1'b1;
            res.status         = rx_err_nxt;
            res.exception_code = (rx_err_nxt == ST_EXCEPT) ? rx_exc_nxt : 8'd0;
            rx_count_nxt       = 17'd0;
            busy_nxt           = 1'b0;
          end else begin
            res.status   = ST_PENDING;
            rx_count_nxt = cnt_inc;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      server_mode_r <= 1'b0;
      max_out_len_r <= MAX_OUT_LEN_RST;
      tid_r         <= '0;
      req_unit_r    <= '0;
      req_func_r    <= '0;
      busy_r        <= 1'b0;
      tx_left_r     <= '0;
      rx_count_r    <= '0;
      rx_len_r      <= '0;
      rx_tid_r      <= '0;
      rx_err_r      <= ST_GOOD;
      rx_exc_r      <= '0;
      rx_unit_r     <= '0;
      rx_func_r     <= '0;
      hdr_left_r    <= '0;
      hdr_last_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SERVER_MODE: server_mode_r <= cfg_wdata[0];
          REG_MAX_OUT_LEN: max_out_len_r <= cfg_wdata;
          default: ;
        endcase
      end
      tid_r      <= tid_nxt;
      req_unit_r <= req_unit_nxt;
      req_func_r <= req_func_nxt;
      busy_r     <= busy_nxt;
      tx_left_r  <= tx_left_nxt;
      rx_count_r <= rx_count_nxt;
      rx_len_r   <= rx_len_nxt;
      rx_tid_r   <= rx_tid_nxt;
      rx_err_r   <= rx_err_nxt;
      rx_exc_r   <= rx_exc_nxt;
      rx_unit_r  <= rx_unit_nxt;
      rx_func_r  <= rx_func_nxt;
      hdr_last_r <= hdr_last_nxt;

      // The header burst and a new input word never compete for the output register,
      // since input is held off while header bytes remain.
      if (hdr_left_r != 3'd0) begin
        if (out_free) begin
          hdr_left_r  <= hdr_left_r - 3'd1;
          out_valid_r <= 1'b1;
        end
      end else if (hdr_start) begin
        hdr_left_r  <= 3'd7;
        out_valid_r <= 1'b1;
      end else if (res_vld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_left_r != 3'd0) begin
      if (out_free) begin
        out_r <= hdr_word;
        hdr_r <= {hdr_r[5:0], 8'h00};
      end
    end else begin
      if (hdr_start) begin
        hdr_r <= hdr_nxt;
      end
      if (res_vld) begin
        out_r <= res;
      end
    end
  end

endmodule
